// ----- hdl/psd_pkg.sv -----
package psd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_RUN,
    ST_FIN
  } state_e;

  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  localparam int unsigned ROW_COUNT_RESET = 480;
  localparam int unsigned COL_COUNT_RESET = 640;
  localparam int unsigned SCALE_FULL      = 255;

  // Permeability weight, exp falloff over the grey difference, 1023 = full pass.
  localparam logic [9:0] MU_ROM [256] = '{
    10'd1023, 10'd989, 10'd957, 10'd925, 10'd895, 10'd865, 10'd837, 10'd810,
    10'd783, 10'd757, 10'd733, 10'd708, 10'd685, 10'd663, 10'd641, 10'd620,
    10'd600, 10'd580, 10'd561, 10'd543, 10'd525, 10'd508, 10'd491, 10'd475,
    10'd459, 10'd444, 10'd430, 10'd415, 10'd402, 10'd389, 10'd376, 10'd364,
    10'd352, 10'd340, 10'd329, 10'd318, 10'd308, 10'd298, 10'd288, 10'd278,
    10'd269, 10'd260, 10'd252, 10'd243, 10'd235, 10'd228, 10'd220, 10'd213,
    10'd206, 10'd199, 10'd193, 10'd186, 10'd180, 10'd174, 10'd169, 10'd163,
    10'd158, 10'd153, 10'd147, 10'd143, 10'd138, 10'd133, 10'd129, 10'd125,
    10'd121, 10'd117, 10'd113, 10'd109, 10'd106, 10'd102, 10'd99, 10'd95,
    10'd92, 10'd89, 10'd86, 10'd83, 10'd81, 10'd78, 10'd75, 10'd73,
    10'd71, 10'd68, 10'd66, 10'd64, 10'd62, 10'd60, 10'd58, 10'd56,
    10'd54, 10'd52, 10'd50, 10'd49, 10'd47, 10'd46, 10'd44, 10'd43,
    10'd41, 10'd40, 10'd39, 10'd37, 10'd36, 10'd35, 10'd34, 10'd33,
    10'd31, 10'd30, 10'd29, 10'd28, 10'd27, 10'd27, 10'd26, 10'd25,
    10'd24, 10'd23, 10'd22, 10'd22, 10'd21, 10'd20, 10'd20, 10'd19,
    10'd18, 10'd18, 10'd17, 10'd16, 10'd16, 10'd15, 10'd15, 10'd14,
    10'd14, 10'd13, 10'd13, 10'd12, 10'd12, 10'd12, 10'd11, 10'd11,
    10'd10, 10'd10, 10'd10, 10'd9, 10'd9, 10'd9, 10'd8, 10'd8,
    10'd8, 10'd8, 10'd7, 10'd7, 10'd7, 10'd7, 10'd6, 10'd6,
    10'd6, 10'd6, 10'd6, 10'd5, 10'd5, 10'd5, 10'd5, 10'd5,
    10'd4, 10'd4, 10'd4, 10'd4, 10'd4, 10'd4, 10'd4, 10'd3,
    10'd3, 10'd3, 10'd3, 10'd3, 10'd3, 10'd3, 10'd3, 10'd2,
    10'd2, 10'd2, 10'd2, 10'd2, 10'd2, 10'd2, 10'd2, 10'd2,
    10'd2, 10'd2, 10'd2, 10'd2, 10'd1, 10'd1, 10'd1, 10'd1,
    10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1,
    10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0
  };

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // ((mu * cost) mod 2^18) >> 10
  function automatic logic [7:0] weighted(input logic [9:0] mu, input logic [8:0] cost);
    logic [18:0] prod;
    prod = 19'(mu) * 19'(cost);
    return prod[17:10];
  endfunction

endpackage

// ----- hdl/permeability_stereo_disparity_top.sv -----
// Stereo disparity by information permeability. One rectified left/right pixel
// pair enters per transaction in raster order and one scaled disparity
// (d*255/DISPARITY_MAX) leaves, with frame_end_o marking the frame's last pixel.
// Once accepted, an item reads the line store, then the disparity candidates
// are walked one per cycle through the single read/write port pair of the
// previous-row cost memory (LINE_WIDTH*(DISPARITY_MAX+1) entries), then the
// result is loaded into the output register once it is free. A new item is
// accepted the cycle after the result is loaded, even while that result
// still waits to be taken. row_count (index 0) and col_count (index 1) are
// written through the plain config port; the user must write them only while
// idle, the block does not enforce it. col_count keeps bits 10:0; 0 acts as 1
// and values above LINE_WIDTH saturate. No clearing pass is needed after reset.
module permeability_stereo_disparity_top #(
  parameter int unsigned LINE_WIDTH    = 1024,
  parameter int unsigned DISPARITY_MAX = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  left_pixel_i,
  input  logic [7:0]  right_pixel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  disparity_o,
  output logic        frame_end_o
);

  localparam int unsigned NUM_D  = DISPARITY_MAX + 1;
  localparam int unsigned DW     = $clog2(NUM_D);
  localparam int unsigned PW     = $clog2(LINE_WIDTH);
  localparam int unsigned CDEPTH = LINE_WIDTH * NUM_D;
  localparam int unsigned AW     = $clog2(CDEPTH);

  psd_pkg::state_e state_q, state_d;

  logic [15:0]   row_count_q;
  logic [10:0]   col_count_q;
  logic [15:0]   row_pos_q;
  logic [PW-1:0] col_pos_q;

  logic [7:0]    rw_q  [NUM_D];
  logic [8:0]    lnc_q [NUM_D];
  logic [7:0]    prev_lp_q;
  logic [7:0]    lp_q;
  logic [PW-1:0] col_q;
  logic          use_diag_q;
  logic [9:0]    mu_r_q;
  logic [9:0]    mu_g_q;
  logic [DW-1:0] d_q;
  logic [9:0]    best_cost_q;
  logic [DW-1:0] best_d_q;
  logic          fe_q;

  logic          out_valid_q;
  logic [7:0]    out_disp_q;
  logic          out_fe_q;

  logic [7:0]    scale_tab [NUM_D];

  // Effective frame geometry.
  logic [PW:0]   cols_eff;
  logic [15:0]   rows_eff;
  logic          last_col, last_row, accept, slot_free, last_d;
  logic [7:0]    ll_rdata;
  logic [8:0]    pc_rdata;
  logic          pc_re;
  logic [AW-1:0] pc_raddr, pc_waddr;

  // Candidate datapath.
  logic          valid_d;
  logic [8:0]    cost9, new_lnc;
  logic [7:0]    rterm, dterm;
  logic [9:0]    total;
  logic          take;

  for (genvar g = 0; g < NUM_D; g++) begin : g_scale
    localparam int unsigned Scaled = (g * psd_pkg::SCALE_FULL) / DISPARITY_MAX;
    assign scale_tab[g] = 8'(Scaled);
  end

  always_comb begin
    if (col_count_q == 11'd0) begin
      cols_eff = (PW+1)'(1);
    end else if (32'(col_count_q) > LINE_WIDTH) begin
      cols_eff = (PW+1)'(LINE_WIDTH);
    end else begin
      cols_eff = (PW+1)'(col_count_q);
    end
    rows_eff = (row_count_q == 16'd0) ? 16'd1 : row_count_q;
  end

  assign last_col  = (32'(col_pos_q) + 32'd1) >= 32'(cols_eff);
  assign last_row  = (32'(row_pos_q) + 32'd1) >= 32'(rows_eff);
  assign in_ready_o = (state_q == psd_pkg::ST_IDLE);
  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign last_d    = (32'(d_q) == DISPARITY_MAX);

  // Left line store: write this pixel, read the previous row's upper-right pixel.
  psd_ram #(.WIDTH(8), .DEPTH(LINE_WIDTH)) u_left_line (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_pos_q),
    .wdata_i (left_pixel_i),
    .re_i    (accept),
    .raddr_i (PW'(col_pos_q + PW'(1))),
    .rdata_o (ll_rdata)
  );

  // Previous-row cost store: read column col+1, write column col, one d per cycle.
  always_comb begin
    pc_re = accept || ((state_q == psd_pkg::ST_RUN) && !last_d);
    if (accept) begin
      pc_raddr = AW'((32'(col_pos_q) + 32'd1) * NUM_D);
    end else begin
      pc_raddr = AW'((32'(col_q) + 32'd1) * NUM_D + 32'(d_q) + 32'd1);
    end
    pc_waddr = AW'(32'(col_q) * NUM_D + 32'(d_q));
  end

  psd_ram #(.WIDTH(9), .DEPTH(CDEPTH)) u_prev_costs (
    .clk_i   (clk_i),
    .we_i    (state_q == psd_pkg::ST_RUN),
    .waddr_i (pc_waddr),
    .wdata_i (new_lnc),
    .re_i    (pc_re),
    .raddr_i (pc_raddr),
    .rdata_o (pc_rdata)
  );

  always_comb begin
    valid_d = 32'(col_q) >= 32'(d_q);
    rterm   = (32'(col_q) > 32'(d_q)) ? psd_pkg::weighted(mu_r_q, lnc_q[d_q]) : 8'd0;
    cost9   = 9'(psd_pkg::absdiff(lp_q, rw_q[d_q])) + 9'(rterm);
    // Keep the old neighbour cost for a candidate not yet in range.
    new_lnc = valid_d ? cost9 : lnc_q[d_q];
    dterm   = use_diag_q ? psd_pkg::weighted(mu_g_q, pc_rdata) : 8'd0;
    total   = 10'(cost9) + 10'(dterm);
    take    = valid_d && ((d_q == '0) || (total < best_cost_q));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      psd_pkg::ST_IDLE: if (accept) state_d = psd_pkg::ST_LOOK;
      psd_pkg::ST_LOOK: state_d = psd_pkg::ST_RUN;
      psd_pkg::ST_RUN:  if (last_d) state_d = psd_pkg::ST_FIN;
      psd_pkg::ST_FIN:  if (slot_free) state_d = psd_pkg::ST_IDLE;
      default:          state_d = psd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psd_pkg::ST_IDLE;
      row_count_q <= 16'(psd_pkg::ROW_COUNT_RESET);
      col_count_q <= 11'(psd_pkg::COL_COUNT_RESET);
      row_pos_q   <= '0;
      col_pos_q   <= '0;
      out_valid_q <= 1'b0;
      d_q         <= '0;
      for (int i = 0; i < NUM_D; i++) begin
        rw_q[i]  <= '0;
        lnc_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          psd_pkg::CFG_ROW_COUNT: row_count_q <= cfg_wdata_i;
          psd_pkg::CFG_COL_COUNT: col_count_q <= cfg_wdata_i[10:0];
          default: ;
        endcase
      end
      if (accept) begin
        // Shift the right window; newest pixel at entry 0.
        for (int i = NUM_D - 1; i > 0; i--) begin
          rw_q[i] <= rw_q[i-1];
        end
        rw_q[0] <= right_pixel_i;
        // Advance the raster position.
        if (last_col) begin
          col_pos_q <= '0;
          row_pos_q <= last_row ? 16'd0 : (row_pos_q + 16'd1);
        end else begin
          col_pos_q <= col_pos_q + PW'(1);
        end
        d_q <= '0;
      end
      if (state_q == psd_pkg::ST_RUN) begin
        lnc_q[d_q] <= new_lnc;
        if (!last_d) d_q <= d_q + DW'(1);
      end
      if ((state_q == psd_pkg::ST_FIN) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lp_q       <= left_pixel_i;
      prev_lp_q  <= left_pixel_i;
      col_q      <= col_pos_q;
      use_diag_q <= (row_pos_q != 16'd0) && !last_col;
      fe_q       <= last_col && last_row;
      mu_r_q     <= (col_pos_q != '0)
                    ? psd_pkg::MU_ROM[psd_pkg::absdiff(left_pixel_i, prev_lp_q)] : 10'd0;
    end
    if (state_q == psd_pkg::ST_LOOK) begin
      mu_g_q <= psd_pkg::MU_ROM[psd_pkg::absdiff(lp_q, ll_rdata)];
    end
    if ((state_q == psd_pkg::ST_RUN) && take) begin
      best_cost_q <= total;
      best_d_q    <= d_q;
    end
    if ((state_q == psd_pkg::ST_FIN) && slot_free) begin
      out_disp_q <= scale_tab[best_d_q];
      out_fe_q   <= fe_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign disparity_o = out_disp_q;
  assign frame_end_o = out_fe_q;

endmodule

// ----- hdl/psd_ram.sv -----
module psd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
